// ----- design/speech_phrase_segmenter_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the phrase segmenter
// Concurrent checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SPEECH_PHRASE_SEGMENTER_MACROS_SVH
`define SPEECH_PHRASE_SEGMENTER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SPS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SPS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SPS_ASSERT_IMP(lbl, ante, cons)
`define SPS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ----- design/sps_pkg.sv -----
// ----------------------------------------------------------------------------
// sps_pkg
// Types, sizes and codes shared by the phrase segmenter modules.
// ----------------------------------------------------------------------------
package sps_pkg;

  localparam int PHRASE_DEPTH  = 65536;   // power of two
  localparam int PREROLL_DEPTH = 8192;    // power of two
  localparam int PH_AW = $clog2(PHRASE_DEPTH);
  localparam int PH_FW = PH_AW + 1;
  localparam int PR_AW = $clog2(PREROLL_DEPTH);
  localparam int PR_FW = PR_AW + 1;
  localparam int CNT_W = 17;
  localparam int CFG_W = 17;
  localparam int CFG_IW = 3;

  localparam logic [1:0] CMD_AUDIO = 2'd0;
  localparam logic [1:0] CMD_FLUSH = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [CFG_IW-1:0] REG_PRE_ROLL  = 3'd0;
  localparam logic [CFG_IW-1:0] REG_PHRASE    = 3'd1;
  localparam logic [CFG_IW-1:0] REG_SIL_END   = 3'd2;
  localparam logic [CFG_IW-1:0] REG_SIL_KEPT  = 3'd3;
  localparam logic [CFG_IW-1:0] REG_SPEECH_MIN = 3'd4;

  localparam logic KIND_READY = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  sample_byte;
    logic        speech_flag;
    logic        chunk_end;
    logic [15:0] read_index;
  } sps_in_t;

  typedef struct packed {
    logic        result_kind;
    logic [16:0] phrase_bytes;
    logic [7:0]  read_byte;
  } sps_out_t;

  typedef struct packed {
    logic item_load;
    logic pre_push;
    logic pre_clear;
    logic copy_start;
    logic copy_run;
    logic append;
    logic close;
    logic rd_issue;
    logic rd_load;
  } sps_cmd_t;

  typedef struct packed {
    logic [1:0] command;
    logic       speech;
    logic       in_phrase;
    logic       copy_done;
    logic       end_hit;
    logic       out_busy;
  } sps_stat_t;

endpackage

// ----- design/sps_ctrl.sv -----
// ----------------------------------------------------------------------------
// sps_ctrl
// Sequencer: takes one beat at a time and steps the datapath through it.
// ----------------------------------------------------------------------------
`include "speech_phrase_segmenter_macros.svh"
module sps_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  sps_pkg::sps_stat_t stat,
  output sps_pkg::sps_cmd_t  cmd
);
  import sps_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_EXEC  = 5'b00010,
    ST_COPY  = 5'b00100,
    ST_CHECK = 5'b01000,
    ST_READ  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic accept;

  assign in_stall = (state_r != ST_IDLE) || stat.out_busy;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    cmd.item_load = accept;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt = ST_IDLE;
        case (stat.command)
          CMD_AUDIO: begin
            if (stat.in_phrase) begin
              cmd.append = 1'b1;
              state_nxt = ST_CHECK;
            end else if (stat.speech) begin
              cmd.copy_start = 1'b1;
              state_nxt = ST_COPY;
            end else begin
              cmd.pre_push = 1'b1;
            end
          end
          CMD_FLUSH: begin
            if (stat.in_phrase) cmd.close = 1'b1;
            else cmd.pre_clear = 1'b1;
          end
          CMD_READ: begin
            cmd.rd_issue = 1'b1;
            state_nxt = ST_READ;
          end
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_COPY: begin
        cmd.copy_run = 1'b1;
        if (stat.copy_done) state_nxt = ST_EXEC;
      end
      ST_CHECK: begin
        cmd.close = stat.end_hit;
        state_nxt = ST_IDLE;
      end
      ST_READ: begin
        cmd.rd_load = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  `SPS_ASSERT_NXT(a_accept_exec, accept, state_r == ST_EXEC)
  `SPS_ASSERT_IMP(a_busy_stall, state_r != ST_IDLE, in_stall)
  `SPS_ASSERT_NXT(a_read_out, state_r == ST_READ, stat.out_busy)

endmodule

// ----- design/sps_datapath.sv -----
// ----------------------------------------------------------------------------
// sps_datapath
// Pre-roll ring, phrase store, counters, configuration and result register.
// ----------------------------------------------------------------------------
module sps_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  sps_pkg::sps_in_t            in_data,
  input  logic                        cfg_we,
  input  logic [sps_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [sps_pkg::CFG_W-1:0]   cfg_wdata,
  input  sps_pkg::sps_cmd_t           cmd,
  output sps_pkg::sps_stat_t          stat,
  output logic                        out_valid,
  input  logic                        out_stall,
  output sps_pkg::sps_out_t           out_data
);
  import sps_pkg::*;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  logic [7:0] pre_mem [PREROLL_DEPTH];
  logic [7:0] ph_mem  [PHRASE_DEPTH];

  sps_in_t item_r;
  logic [13:0] lim_pre_r;
  logic [16:0] lim_phrase_r, lim_sil_r, kept_r, min_speech_r;

  logic [PR_AW-1:0] head_r;
  logic [PR_FW-1:0] pfill_r;
  logic [PR_AW-1:0] src_r;
  logic [PR_FW-1:0] ncopy_r, ccnt_r;
  logic             pv_r;
  logic [7:0]       pre_q_r;

  logic [PH_FW-1:0] fill_r;
  logic [CNT_W-1:0] speech_r, sil_r;
  logic             in_phrase_r;
  logic [PH_FW-1:0] ready_r;
  logic [7:0]       ph_q_r;
  logic             rd_hit_r;

  logic     out_valid_r;
  sps_out_t out_r;

  // combinational helpers
  logic [31:0] lim_eff, pfill_inc, ncopy_w, fill_w, trim_w, trimmed, idx_w;
  logic        ph_we, full, report, end_hit;
  logic [PH_AW-1:0] ph_wa;
  logic [7:0]  ph_wd;

  always_comb begin
    lim_eff   = (32'(lim_pre_r) > 32'(PREROLL_DEPTH)) ? 32'(PREROLL_DEPTH) : 32'(lim_pre_r);
    pfill_inc = 32'(pfill_r) + 32'd1;
    ncopy_w   = (32'(pfill_r) > 32'(PHRASE_DEPTH)) ? 32'(PHRASE_DEPTH) : 32'(pfill_r);
    fill_w    = 32'(fill_r);
    full      = fill_w >= 32'(PHRASE_DEPTH);
    end_hit   = full || (item_r.chunk_end &&
                ((fill_w >= 32'(lim_phrase_r)) || (sil_r >= lim_sil_r)));
    trim_w    = 32'(sil_r) - 32'(kept_r);
    trimmed   = ((sil_r > kept_r) && (trim_w <= fill_w)) ? fill_w - trim_w : fill_w;
    report    = speech_r >= min_speech_r;
    idx_w     = 32'(item_r.read_index);
    // one write port: copy beats or appended byte
    ph_we = 1'b0;
    ph_wa = fill_r[PH_AW-1:0];
    ph_wd = item_r.sample_byte;
    if (cmd.copy_run && pv_r) begin
      ph_we = 1'b1;
      ph_wd = pre_q_r;
    end else if (cmd.append && !full) begin
      ph_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pre_push && lim_eff != 32'd0) pre_mem[head_r] <= item_r.sample_byte;
    if (cmd.copy_run && ccnt_r < ncopy_r) pre_q_r <= pre_mem[src_r + ccnt_r[PR_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (ph_we) ph_mem[ph_wa] <= ph_wd;
    if (cmd.rd_issue) ph_q_r <= ph_mem[idx_w[PH_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.item_load) item_r <= in_data;
    if (cmd.copy_start) begin
      src_r   <= head_r - ncopy_w[PR_AW-1:0];
      ncopy_r <= ncopy_w[PR_FW-1:0];
    end
    if (cmd.rd_issue)
      rd_hit_r <= (idx_w < 32'(ready_r)) && (idx_w < 32'(PHRASE_DEPTH));
    if (cmd.close && report) begin
      out_r.result_kind  <= KIND_READY;
      out_r.phrase_bytes <= trimmed[16:0];
      out_r.read_byte    <= 8'd0;
    end else if (cmd.rd_load) begin
      out_r.result_kind  <= KIND_READ;
      out_r.phrase_bytes <= 17'(ready_r);
      out_r.read_byte    <= rd_hit_r ? ph_q_r : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_pre_r    <= 14'd8000;
      lim_phrase_r <= 17'd65536;
      lim_sil_r    <= 17'd16000;
      kept_r       <= 17'd3200;
      min_speech_r <= 17'd6400;
      head_r       <= '0;
      pfill_r      <= '0;
      ccnt_r       <= '0;
      pv_r         <= 1'b0;
      fill_r       <= '0;
      speech_r     <= '0;
      sil_r        <= '0;
      in_phrase_r  <= 1'b0;
      ready_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_PRE_ROLL:   lim_pre_r    <= cfg_wdata[13:0];
          REG_PHRASE:     lim_phrase_r <= cfg_wdata;
          REG_SIL_END:    lim_sil_r    <= cfg_wdata;
          REG_SIL_KEPT:   kept_r       <= cfg_wdata;
          REG_SPEECH_MIN: min_speech_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.pre_push) begin
        if (lim_eff == 32'd0) begin
          pfill_r <= '0;
        end else begin
          head_r  <= head_r + 1'b1;
          pfill_r <= (pfill_inc > lim_eff) ? lim_eff[PR_FW-1:0] : pfill_inc[PR_FW-1:0];
        end
      end
      if (cmd.pre_clear) begin
        head_r  <= '0;
        pfill_r <= '0;
      end
      if (cmd.copy_start) begin
        // ring pointers were captured; empty the ring and open the phrase
        head_r      <= '0;
        pfill_r     <= '0;
        ccnt_r      <= '0;
        pv_r        <= 1'b0;
        fill_r      <= '0;
        speech_r    <= '0;
        sil_r       <= '0;
        ready_r     <= '0;
        in_phrase_r <= 1'b1;
      end
      if (cmd.copy_run) begin
        pv_r <= ccnt_r < ncopy_r;
        if (ccnt_r < ncopy_r) ccnt_r <= ccnt_r + 1'b1;
        if (pv_r) fill_r <= fill_r + 1'b1;
      end
      if (cmd.append) begin
        if (!full) fill_r <= fill_r + 1'b1;
        if (item_r.speech_flag) begin
          if (speech_r != CNT_MAX) speech_r <= speech_r + 1'b1;
          sil_r <= '0;
        end else if (sil_r != CNT_MAX) begin
          sil_r <= sil_r + 1'b1;
        end
      end
      if (cmd.close) begin
        if (report) ready_r <= trimmed[PH_FW-1:0];
        fill_r      <= '0;
        speech_r    <= '0;
        sil_r       <= '0;
        in_phrase_r <= 1'b0;
      end
      if ((cmd.close && report) || cmd.rd_load) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
    end
  end

  assign stat.command   = item_r.command;
  assign stat.speech    = item_r.speech_flag;
  assign stat.in_phrase = in_phrase_r;
  assign stat.copy_done = (ccnt_r == ncopy_r) && !pv_r;
  assign stat.end_hit   = end_hit;
  assign stat.out_busy  = out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- design/speech_phrase_segmenter.sv -----
// ----------------------------------------------------------------------------
// speech_phrase_segmenter
// Cuts a tagged PCM byte stream into phrases with pre-roll and silence trim.
// ----------------------------------------------------------------------------
// One beat is taken at a time. An audio byte outside a phrase, a flush or an
// unused command passes through the execute state only; an audio byte inside
// a phrase then passes through the end check state, and a read through the
// read state. The byte that opens a phrase first copies the pre-roll ring into
// the phrase store through the single read port of the ring, and is then
// appended. A new beat is held off while a result waits on the output
// register, and for as long as out_stall holds that result.
module speech_phrase_segmenter (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  sps_pkg::sps_in_t            in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output sps_pkg::sps_out_t           out_data,
  input  logic                        cfg_we,
  input  logic [sps_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [sps_pkg::CFG_W-1:0]   cfg_wdata
);
  import sps_pkg::*;

  sps_cmd_t  cmd;
  sps_stat_t stat;

  sps_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .stat(stat), .cmd(cmd)
  );

  sps_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .in_data(in_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .cmd(cmd), .stat(stat),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Phrase segmenter testbench
// Drives tagged audio bytes, flushes and reads through the valid/stall
// channels, predicts each result from a behavioral copy of the segmenter
// and compares every result beat field by field, in order.
// ----------------------------------------------------------------------------
import sps_pkg::*;

class phrase_scoreboard;
  bit [7:0]  ring_mem[PREROLL_DEPTH];
  bit [7:0]  phrase_mem[PHRASE_DEPTH];
  int        ring_head, ring_fill, phrase_fill, speech_cnt, silence_cnt;
  bit        open;
  int        ready_len;
  int        pre_lim, phrase_lim, sil_end, sil_kept, speech_min;
  sps_out_t  expected_q[$];
  int        errors, checked, phrases_seen, reads_seen;

  function new();
    pre_lim = 8000; phrase_lim = 65536; sil_end = 16000;
    sil_kept = 3200; speech_min = 6400;
  endfunction

  function void set_reg(logic [CFG_IW-1:0] idx, int val);
    case (idx)
      REG_PRE_ROLL:   pre_lim    = val & 16'h3FFF;
      REG_PHRASE:     phrase_lim = val & 17'h1FFFF;
      REG_SIL_END:    sil_end    = val & 17'h1FFFF;
      REG_SIL_KEPT:   sil_kept   = val & 17'h1FFFF;
      REG_SPEECH_MIN: speech_min = val & 17'h1FFFF;
      default: ;
    endcase
  endfunction

  // close the open phrase; returns 1 when a ready beat is due
  function bit close_phrase();
    bit report;
    if (silence_cnt > sil_kept && silence_cnt - sil_kept <= phrase_fill)
      phrase_fill -= silence_cnt - sil_kept;
    report = speech_cnt >= speech_min;
    if (report) ready_len = phrase_fill;
    phrase_fill = 0; speech_cnt = 0; silence_cnt = 0; open = 0;
    return report;
  endfunction

  function void push_ready();
    sps_out_t r;
    r.result_kind = KIND_READY; r.phrase_bytes = ready_len[16:0]; r.read_byte = '0;
    expected_q.push_back(r);
  endfunction

  function void note(sps_in_t it);
    sps_out_t r;
    int lim, n, src;
    bit done;
    done = 0;
    case (it.command)
      CMD_AUDIO: begin
        if (!open && !it.speech_flag) begin
          lim = pre_lim > PREROLL_DEPTH ? PREROLL_DEPTH : pre_lim;
          if (lim == 0) ring_fill = 0;
          else begin
            ring_mem[ring_head] = it.sample_byte;
            ring_head = (ring_head + 1) % PREROLL_DEPTH;
            ring_fill = ring_fill + 1 > lim ? lim : ring_fill + 1;
          end
          return;
        end
        if (!open) begin
          n = ring_fill;
          src = (ring_head + PREROLL_DEPTH - n) % PREROLL_DEPTH;
          phrase_fill = 0;
          for (int i = 0; i < n; i++) begin
            phrase_mem[phrase_fill] = ring_mem[src];
            phrase_fill = phrase_fill + 1;
            src = (src + 1) % PREROLL_DEPTH;
          end
          ring_head = 0; ring_fill = 0;
          speech_cnt = 0; silence_cnt = 0; ready_len = 0; open = 1;
        end
        if (phrase_fill < PHRASE_DEPTH) begin
          phrase_mem[phrase_fill] = it.sample_byte;
          phrase_fill = phrase_fill + 1;
        end
        if (it.speech_flag) begin
          if (speech_cnt < 17'h1FFFF) speech_cnt++;
          silence_cnt = 0;
        end else if (silence_cnt < 17'h1FFFF) silence_cnt++;
        if (phrase_fill >= PHRASE_DEPTH) done = 1;
        else if (it.chunk_end && (phrase_fill >= phrase_lim || silence_cnt >= sil_end))
          done = 1;
        if (done && close_phrase()) push_ready();
      end
      CMD_FLUSH: begin
        if (!open) begin
          ring_head = 0; ring_fill = 0;
        end else if (close_phrase()) push_ready();
      end
      CMD_READ: begin
        r.result_kind  = KIND_READ;
        r.phrase_bytes = ready_len[16:0];
        r.read_byte    = (it.read_index < ready_len) ? phrase_mem[it.read_index] : 8'h00;
        expected_q.push_back(r);
      end
      default: ;
    endcase
  endfunction

  function void check(sps_out_t got);
    sps_out_t want;
    if (expected_q.size() == 0) begin
      $error("unexpected result beat: %h", got);
      errors++;
      return;
    end
    want = expected_q.pop_front();
    checked++;
    if (want.result_kind == KIND_READY) phrases_seen++; else reads_seen++;
    if (got.result_kind !== want.result_kind) begin
      $error("result_kind: expected %0d, got %0d", want.result_kind, got.result_kind);
      errors++;
    end
    if (got.phrase_bytes !== want.phrase_bytes) begin
      $error("phrase_bytes: expected %0d, got %0d", want.phrase_bytes, got.phrase_bytes);
      errors++;
    end
    if (got.read_byte !== want.read_byte) begin
      $error("read_byte: expected %0d, got %0d", want.read_byte, got.read_byte);
      errors++;
    end
  endfunction
endclass

module tb_top;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic      clk = 0;
  logic      rst_n = 0;
  logic      in_valid = 0;
  logic      in_stall;
  sps_in_t   in_data = '0;
  logic      out_valid;
  logic      out_stall = 0;
  sps_out_t  out_data;
  logic      cfg_we = 0;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [CFG_W-1:0]  cfg_wdata = '0;

  phrase_scoreboard sb = new();
  bit  send_gaps = 1, recv_gaps = 1;
  int  hold_req = 0, hold_cnt = 0;
  int  beats_in = 0;

  speech_phrase_segmenter dut (.*);

  always #4 clk = ~clk;

  // result side: random stall, long hold-off on request
  always @(posedge clk) begin
    if (out_valid && !out_stall) sb.check(out_data);
    if (hold_req > 0) begin
      hold_cnt = hold_req;
      hold_req = 0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else if (!recv_gaps) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 9) < 3);
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!send_gaps || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  task automatic offer(sps_in_t it);
    int g;
    g = pick_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    sb.note(it);
    beats_in++;
  endtask

  task automatic audio(bit [7:0] b, bit sp, bit last);
    sps_in_t it;
    it = '0;
    it.command = CMD_AUDIO; it.sample_byte = b; it.speech_flag = sp; it.chunk_end = last;
    it.read_index = 16'($urandom);
    offer(it);
  endtask

  task automatic simple(logic [1:0] cmd, bit [15:0] idx);
    sps_in_t it;
    it = sps_in_t'($urandom);
    it.command = cmd; it.read_index = idx;
    offer(it);
  endtask

  // wait out every expected beat plus the longest pre-roll copy
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (PREROLL_DEPTH + 100) @(posedge clk);
  endtask

  task automatic set_regs(int pre, int plim, int send, int kept, int smin);
    int vals[5];
    vals = '{pre, plim, send, kept, smin};
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= i[CFG_IW-1:0];
      cfg_wdata <= vals[i][CFG_W-1:0];
      sb.set_reg(i[CFG_IW-1:0], vals[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // well-formed chunks with random content, plus flushes, reads and noise
  task automatic random_traffic(int n_items);
    int sent, len, r;
    bit sp;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        len = $urandom_range(1, 8);
        sp = ($urandom_range(0, 9) < 5);
        for (int i = 0; i < len; i++) audio(8'($urandom), sp, i == len - 1);
        sent += len;
      end else begin
        if (r < 74) simple(CMD_FLUSH, 16'($urandom));
        else if (r < 76) simple(CMD_UNUSED, 16'($urandom));
        else if (r < 80) simple(CMD_READ, 16'($urandom));
        else simple(CMD_READ,
                    sb.ready_len > 0 ? 16'($urandom_range(0, sb.ready_len)) : 16'd0);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: tiny sizes, every command and corner
    set_regs(4, 8, 3, 1, 2);
    simple(CMD_READ, 16'd0);
    simple(CMD_UNUSED, 16'hFFFF);
    simple(CMD_FLUSH, 16'd0);
    for (int i = 0; i < 6; i++) audio(i == 0 ? 8'h00 : 8'hFF, 1'b0, i == 5);
    audio(8'hA5, 1'b1, 1'b0);
    audio(8'h5A, 1'b1, 1'b1);
    for (int i = 0; i < 3; i++) audio(8'(8'h10 + i), 1'b0, i == 2);
    simple(CMD_READ, 16'd0);
    simple(CMD_READ, 16'd4);
    simple(CMD_READ, 16'hFFFF);
    audio(8'h33, 1'b1, 1'b1);
    simple(CMD_FLUSH, 16'd0);
    simple(CMD_READ, 16'd0);
    audio(8'h44, 1'b0, 1'b1);
    simple(CMD_FLUSH, 16'd0);
    audio(8'h77, 1'b1, 1'b0);
    simple(CMD_READ, 16'd0);
    drain();

    // receiver holds off while reads keep coming, so the block backs up
    set_regs(2, 20, 4, 2, 0);
    hold_req = 400;
    for (int i = 0; i < 30; i++) simple(CMD_READ, 16'($urandom));
    random_traffic(150);
    drain();

    // pre-roll overrun past its limit, handed over to a long phrase, then read back
    send_gaps = 0; recv_gaps = 0;
    set_regs(300, 65536, 65536, 65536, 0);
    for (int i = 0; i < 340; i++) audio(8'($urandom), 1'b0, 1'($urandom_range(0, 1)));
    for (int i = 0; i < 100; i++) audio(8'($urandom), 1'b1, 1'($urandom_range(0, 1)));
    simple(CMD_FLUSH, 16'd0);
    simple(CMD_READ, 16'd0);
    simple(CMD_READ, 16'd399);
    simple(CMD_READ, 16'hFFFF);
    drain();

    // limit above depth clamps; zero keeps nothing; strict speech minimum
    set_regs(16383, 1, 1, 0, 65536);
    random_traffic(40);
    drain();
    send_gaps = 1; recv_gaps = 1;
    set_regs(0, 65536, 1, 0, 1);
    random_traffic(120);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      send_gaps = (ph != 3);
      recv_gaps = (ph != 5);
      set_regs($urandom_range(0, 16), $urandom_range(4, 64), $urandom_range(1, 20),
               $urandom_range(0, 10), $urandom_range(0, 10));
      random_traffic(120);
      drain();
    end

    $display("Sent %0d input beats; checked %0d results (%0d phrases, %0d reads).",
             beats_in, sb.checked, sb.phrases_seen, sb.reads_seen);
    $display("Covered pre-roll wrap and handover, trims, drops, flushes and reads.");
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("Simulation FAILED");
    $finish;
  end
endmodule
